>>> hdl/uvs_pkg.sv
package uvs_pkg;

   // default parameter values
   localparam int MAX_SLICES_DEF = 255;
   localparam int MAX_STACKS_DEF = 255;
   localparam int ANGLE_BITS_DEF = 16;

   // cordic constants, angles in units of 2^-32 turn
   localparam int CORDIC_STEPS = 24;
   localparam int CW           = 33;
   localparam logic signed [CW-1:0] CORDIC_GAIN = 33'sd652032874;
   localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
      32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722,
      32'd20861, 32'd10430, 32'd5215, 32'd2608, 32'd1304,
      32'd652, 32'd326, 32'd163, 32'd81
   };

   localparam int MIN_SLICES = 3;
   localparam int MIN_STACKS = 2;

   // register indexes
   typedef enum logic [1:0] {
      REG_RADIUS = 2'd0,
      REG_SLICES = 2'd1,
      REG_STACKS = 2'd2,
      REG_COLOR  = 2'd3
   } reg_index_type;

   // per-beat sideband carried alongside the math pipeline
   typedef struct packed {
      logic        coord_error;
      logic        quad_valid;
      logic [15:0] vertex_index;
      logic [15:0] stride;
   } side_type;

endpackage

>>> hdl/uvs_div.sv
module uvs_div #(
   parameter int ANGLE_BITS = uvs_pkg::ANGLE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  en,
   input  logic [ANGLE_BITS+8:0] numer,
   input  logic [7:0]            denom,
   output logic [ANGLE_BITS:0]   quot
);

   localparam int QW = ANGLE_BITS + 1;
   localparam int NW = ANGLE_BITS + 9;

   logic [7:0]    rem_ff [0:QW];
   logic [NW-1:0] num_ff [0:QW];
   logic [7:0]    den_ff [0:QW];
   logic [QW-1:0] q_ff   [0:QW];

   // input capture, leading bits form the first partial remainder
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= numer[NW-1:QW];
         num_ff[0] <= numer;
         den_ff[0] <= denom;
         q_ff[0]   <= '0;
      end
   end

   // one restoring step per stage, msb first
   for (genvar j = 0; j < QW; j++) begin : g_step
      logic [8:0]    trial;
      logic [7:0]    rem_in;
      logic [QW-1:0] q_in;
      always_comb begin
         trial  = {rem_ff[j], num_ff[j][QW-1-j]};
         rem_in = trial[7:0];
         q_in   = q_ff[j];
         if (trial >= {1'b0, den_ff[j]}) begin
            rem_in         = 8'(trial - {1'b0, den_ff[j]});
            q_in[QW-1-j]   = 1'b1;
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j+1] <= rem_in;
            num_ff[j+1] <= num_ff[j];
            den_ff[j+1] <= den_ff[j];
            q_ff[j+1]   <= q_in;
         end
      end
   end

   assign quot = q_ff[QW];

endmodule

>>> hdl/uvs_cordic.sv
module uvs_cordic (
   input  logic                           clock,
   input  logic                           en,
   input  logic [31:0]                    turn,
   output logic signed [uvs_pkg::CW-1:0]  sin_ff,
   output logic signed [uvs_pkg::CW-1:0]  cos_ff
);

   localparam int N  = uvs_pkg::CORDIC_STEPS;
   localparam int CW = uvs_pkg::CW;

   logic signed [CW-1:0] x_ff [0:N];
   logic signed [CW-1:0] y_ff [0:N];
   logic signed [CW-1:0] z_ff [0:N];
   logic [1:0]           quad_ff [0:N];
   logic signed [CW-1:0] sin_in, cos_in;

   // load start vector, residual angle within the quadrant
   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]    <= uvs_pkg::CORDIC_GAIN;
         y_ff[0]    <= '0;
         z_ff[0]    <= CW'(turn[29:0]);
         quad_ff[0] <= turn[31:30];
      end
   end

   // one micro-rotation per stage
   for (genvar i = 0; i < N; i++) begin : g_rot
      logic signed [CW-1:0] x_in, y_in, z_in;
      logic signed [CW-1:0] a;
      always_comb begin
         a = CW'(uvs_pkg::ATAN_TURNS[i]);
         if (z_ff[i] >= 0) begin
            x_in = x_ff[i] - (y_ff[i] >>> i);
            y_in = y_ff[i] + (x_ff[i] >>> i);
            z_in = z_ff[i] - a;
         end else begin
            x_in = x_ff[i] + (y_ff[i] >>> i);
            y_in = y_ff[i] - (x_ff[i] >>> i);
            z_in = z_ff[i] + a;
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[i+1]    <= x_in;
            y_ff[i+1]    <= y_in;
            z_ff[i+1]    <= z_in;
            quad_ff[i+1] <= quad_ff[i];
         end
      end
   end

   // quadrant fold
   always_comb begin
      case (quad_ff[N])
         2'd0: begin cos_in = x_ff[N];  sin_in = y_ff[N];  end
         2'd1: begin cos_in = -y_ff[N]; sin_in = x_ff[N];  end
         2'd2: begin cos_in = -x_ff[N]; sin_in = -y_ff[N]; end
         default: begin cos_in = y_ff[N]; sin_in = -x_ff[N]; end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sin_ff <= sin_in;
         cos_ff <= cos_in;
      end
   end

endmodule

>>> hdl/uv_sphere_vertex_generator_unit.sv
// throughput: one beat per cycle while rsp is not stalled, set by the bit-per-stage angle dividers,
//   the 24-stage cordic pipelines and two multiply stages
// a stalled rsp side freezes the whole pipeline, nothing is dropped
// reset: synchronous, active high; clears valid bits and loads register defaults
//   (radius 1.0, 16 slices, 8 stacks, colour all ones)
module uv_sphere_vertex_generator_unit #(
   parameter int MAX_SLICES = uvs_pkg::MAX_SLICES_DEF,
   parameter int MAX_STACKS = uvs_pkg::MAX_STACKS_DEF,
   parameter int ANGLE_BITS = uvs_pkg::ANGLE_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [15:0]  req_tdata,   // ring[7:0], segment[15:8]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // vertex_index[15:0], pos_x[32:16], pos_y[49:33], pos_z[66:50],
   // vertex_color[130:67], corner_a[146:131], corner_b[162:147],
   // corner_c[178:163], corner_d[194:179], zero pad[199:195]
   output logic [199:0] rsp_tdata,
   output logic [1:0]   rsp_tuser,   // quad_valid[0], coord_error[1]
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [63:0]  csr_data
);

   localparam int NW  = ANGLE_BITS + 9;
   localparam int LAT = ANGLE_BITS + 30;
   localparam int CW  = uvs_pkg::CW;
   localparam logic [11:0] MAX_S = 12'(MAX_SLICES);
   localparam logic [11:0] MAX_T = 12'(MAX_STACKS);

   logic [15:0] radius_ff;
   logic [7:0]  slices_ff, stacks_ff;
   logic [63:0] color_ff;

   // configuration registers
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= 16'd256;
         slices_ff <= 8'd16;
         stacks_ff <= 8'd8;
         color_ff  <= '1;
      end else if (csr_valid) begin
         case (uvs_pkg::reg_index_type'(csr_index))
            uvs_pkg::REG_RADIUS: radius_ff <= csr_data[15:0];
            uvs_pkg::REG_SLICES: slices_ff <= csr_data[7:0];
            uvs_pkg::REG_STACKS: stacks_ff <= csr_data[7:0];
            uvs_pkg::REG_COLOR:  color_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // effective grid size
   logic [7:0] slices_eff, stacks_eff;
   always_comb begin
      slices_eff = (slices_ff < 8'(uvs_pkg::MIN_SLICES)) ? 8'(uvs_pkg::MIN_SLICES) : slices_ff;
      if (12'(slices_eff) > MAX_S) slices_eff = MAX_S[7:0];
      stacks_eff = (stacks_ff < 8'(uvs_pkg::MIN_STACKS)) ? 8'(uvs_pkg::MIN_STACKS) : stacks_ff;
      if (12'(stacks_eff) > MAX_T) stacks_eff = MAX_T[7:0];
   end

   // pipeline advance
   logic              en;
   logic              vld_ff  [0:LAT-1];
   uvs_pkg::side_type side_ff [0:LAT-1];
   assign en         = !vld_ff[LAT-1] || rsp_tready;
   assign req_tready = en;

   // input stage: index math and divider numerators
   logic [7:0]        ring, seg;
   logic [8:0]        stride;
   logic [16:0]       idx_full;
   logic [NW-1:0]     th_num, ph_num;
   uvs_pkg::side_type side_in;
   always_comb begin
      ring     = req_tdata[7:0];
      seg      = req_tdata[15:8];
      stride   = {1'b0, slices_eff} + 9'd1;
      idx_full = 17'(ring) * 17'(stride) + 17'(seg);
      side_in.coord_error  = (ring > stacks_eff) || (seg > slices_eff);
      side_in.quad_valid   = (ring < stacks_eff) && (seg < slices_eff);
      side_in.vertex_index = idx_full[15:0];
      side_in.stride       = 16'(stride);
      th_num = (NW'(seg) << ANGLE_BITS) + NW'(slices_eff >> 1);
      ph_num = (NW'(ring) << (ANGLE_BITS - 1)) + NW'(stacks_eff >> 1);
   end

   // valid and sideband line
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < LAT; k++) vld_ff[k] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= req_tvalid;
         for (int k = 1; k < LAT; k++) vld_ff[k] <= vld_ff[k-1];
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= side_in;
         for (int k = 1; k < LAT; k++) side_ff[k] <= side_ff[k-1];
      end
   end

   // angle division
   logic [ANGLE_BITS:0] th_q, ph_q;
   uvs_div #(.ANGLE_BITS(ANGLE_BITS)) u_div_th (
      .clock(clock), .en(en), .numer(th_num), .denom(slices_eff), .quot(th_q)
   );
   uvs_div #(.ANGLE_BITS(ANGLE_BITS)) u_div_ph (
      .clock(clock), .en(en), .numer(ph_num), .denom(stacks_eff), .quot(ph_q)
   );

   // sine and cosine
   logic [31:0]          th_turn, ph_turn;
   logic signed [CW-1:0] st, ct, sp, cp;
   assign th_turn = 32'({th_q, {(32 - ANGLE_BITS){1'b0}}});
   assign ph_turn = 32'({ph_q, {(32 - ANGLE_BITS){1'b0}}});
   uvs_cordic u_cordic_th (.clock(clock), .en(en), .turn(th_turn), .sin_ff(st), .cos_ff(ct));
   uvs_cordic u_cordic_ph (.clock(clock), .en(en), .turn(ph_turn), .sin_ff(sp), .cos_ff(cp));

   function automatic logic signed [16:0] sat17(input logic signed [23:0] v);
      if (v > 24'sd65535) return 17'sd65535;
      if (v < -24'sd65535) return -17'sd65535;
      return v[16:0];
   endfunction

   // first multiply: ring radius and pos_y
   logic signed [16:0]    r;
   logic signed [49:0]    rs_prod, py_prod;
   logic signed [19:0]    rs_in, rs_ff;
   logic signed [16:0]    py_in, py_ff;
   logic signed [CW-1:0]  st_ff, ct_ff;
   logic signed [23:0]    py_rnd;
   always_comb begin
      r       = signed'({1'b0, radius_ff});
      rs_prod = 50'(r) * 50'(sp);
      py_prod = 50'(r) * 50'(cp);
      rs_in   = 20'((rs_prod + 50'sd536870912) >>> 30);
      py_rnd  = 24'((py_prod + 50'sd536870912) >>> 30);
      py_in   = sat17(py_rnd);
   end
   always_ff @(posedge clock) begin
      if (en) begin
         rs_ff <= rs_in;
         py_ff <= py_in;
         st_ff <= st;
         ct_ff <= ct;
      end
   end

   // second multiply: pos_x and pos_z, output register
   logic signed [52:0] px_prod, pz_prod;
   logic signed [23:0] px_rnd, pz_rnd;
   logic signed [16:0] px_in, pz_in, px_ff, pz_ff, py2_ff;
   always_comb begin
      px_prod = 53'(rs_ff) * 53'(ct_ff);
      pz_prod = 53'(rs_ff) * 53'(st_ff);
      px_rnd  = 24'((px_prod + 53'sd536870912) >>> 30);
      pz_rnd  = 24'((pz_prod + 53'sd536870912) >>> 30);
      px_in   = sat17(px_rnd);
      pz_in   = sat17(pz_rnd);
   end
   always_ff @(posedge clock) begin
      if (en) begin
         px_ff  <= px_in;
         pz_ff  <= pz_in;
         py2_ff <= py_ff;
      end
   end

   // result beat assembly
   uvs_pkg::side_type so;
   logic [15:0] ca, cb, cc, cd;
   always_comb begin
      so = side_ff[LAT-1];
      ca = so.vertex_index;
      cb = ca + 16'd1;
      cc = ca + so.stride;
      cd = cc + 16'd1;
      if (!so.quad_valid) begin
         ca = '0; cb = '0; cc = '0; cd = '0;
      end
      rsp_tdata = {5'd0, cd, cc, cb, ca, color_ff, pz_ff, py2_ff, px_ff, so.vertex_index};
      rsp_tuser = {so.coord_error, so.quad_valid};
      if (so.coord_error) begin
         rsp_tdata = '0;
         rsp_tuser = 2'b10;
      end
   end
   assign rsp_tvalid = vld_ff[LAT-1];

   // checks
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tdata == '0 && !rsp_tuser[0])
      else $error("error beat carries data");
   a_stall_freeze: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("pipeline accepts while output stalled");

endmodule

>>> test/uv_sphere_vertex_generator_unit_tb.sv
`timescale 1ns / 1ps

module uv_sphere_vertex_generator_unit_tb;

   localparam int LATENCY    = uvs_pkg::ANGLE_BITS_DEF + 30;
   localparam int WATCHDOG   = 20000;
   localparam int N_RANDOM   = 1830;
   localparam int N_ROWS     = 11;

   // one expected vertex beat
   typedef struct packed {
      logic        coord_error;
      logic        quad_valid;
      logic [15:0] vertex_index;
      logic [16:0] pos_x;
      logic [16:0] pos_y;
      logic [16:0] pos_z;
      logic [63:0] vertex_color;
      logic [15:0] corner_a;
      logic [15:0] corner_b;
      logic [15:0] corner_c;
      logic [15:0] corner_d;
   } vertex_type;

   // directed stimulus row; has_known marks rows whose result is typed in
   typedef struct {
      logic [7:0] ring;
      logic [7:0] segment;
      bit         has_known;
      vertex_type known;
   } row_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [15:0]  req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [199:0] rsp_tdata;
   logic [1:0]   rsp_tuser;
   logic         csr_valid;
   logic         csr_ready;
   logic [1:0]   csr_index;
   logic [63:0]  csr_data;

   // shadow copy of the registers
   logic [15:0] radius_reg;
   logic [7:0]  slices_reg;
   logic [7:0]  stacks_reg;
   logic [63:0] color_reg;

   vertex_type pending_vertices[$];
   int  error_count;
   int  idle_cycles;
   int  send_idle_pct;
   int  recv_stall_pct;
   bit  hold_rsp;
   bit  rsp_free;

   uv_sphere_vertex_generator_unit dut (.*);

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // arithmetic shift right with floor
   function automatic longint floor_shr(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint round_q30(longint v);
      return floor_shr(v + (longint'(1) << 29), 30);
   endfunction

   function automatic logic [16:0] sat_pos(longint v);
      if (v > 65535) v = 65535;
      if (v < -65535) v = -65535;
      return v[16:0];
   endfunction

   // rotation by cordic, angle in turns scaled to 2^32
   task automatic rotate(input logic [31:0] turn, output longint sn, output longint cs);
      longint x, y, z, dx, dy;
      x = uvs_pkg::CORDIC_GAIN;
      y = 0;
      z = longint'(turn[29:0]);
      for (int i = 0; i < uvs_pkg::CORDIC_STEPS; i++) begin
         dx = floor_shr(y, i);
         dy = floor_shr(x, i);
         if (z >= 0) begin
            x -= dx; y += dy; z -= longint'(uvs_pkg::ATAN_TURNS[i]);
         end else begin
            x += dx; y -= dy; z += longint'(uvs_pkg::ATAN_TURNS[i]);
         end
      end
      case (turn[31:30])
         2'd0: begin cs = x;  sn = y;  end
         2'd1: begin cs = -y; sn = x;  end
         2'd2: begin cs = -x; sn = -y; end
         default: begin cs = y; sn = -x; end
      endcase
   endtask

   // vertex position and quad corners for one grid point
   task automatic compute_vertex(input logic [7:0] ring, input logic [7:0] segment,
                                 output vertex_type v);
      longint slices, stacks, stride, idx, th, ph, st, ct, sp, cp, rs, r;
      v = '0;
      slices = slices_reg < uvs_pkg::MIN_SLICES ? uvs_pkg::MIN_SLICES : slices_reg;
      stacks = stacks_reg < uvs_pkg::MIN_STACKS ? uvs_pkg::MIN_STACKS : stacks_reg;
      if (slices > uvs_pkg::MAX_SLICES_DEF) slices = uvs_pkg::MAX_SLICES_DEF;
      if (stacks > uvs_pkg::MAX_STACKS_DEF) stacks = uvs_pkg::MAX_STACKS_DEF;
      if (ring > stacks || segment > slices) begin
         v.coord_error = 1'b1;
         return;
      end
      stride = slices + 1;
      idx = ring * stride + segment;
      th = (segment * (longint'(1) << uvs_pkg::ANGLE_BITS_DEF) + slices / 2) / slices;
      ph = (ring * (longint'(1) << (uvs_pkg::ANGLE_BITS_DEF - 1)) + stacks / 2) / stacks;
      rotate(32'(th << (32 - uvs_pkg::ANGLE_BITS_DEF)), st, ct);
      rotate(32'(ph << (32 - uvs_pkg::ANGLE_BITS_DEF)), sp, cp);
      r = radius_reg;
      rs = round_q30(r * sp);
      v.vertex_index = idx[15:0];
      v.pos_x = sat_pos(round_q30(rs * ct));
      v.pos_y = sat_pos(round_q30(r * cp));
      v.pos_z = sat_pos(round_q30(rs * st));
      v.vertex_color = color_reg;
      if (ring < stacks && segment < slices) begin
         v.quad_valid = 1'b1;
         v.corner_a = idx[15:0];
         v.corner_b = 16'(idx + 1);
         v.corner_c = 16'(idx + stride);
         v.corner_d = 16'(idx + stride + 1);
      end
   endtask

   function automatic vertex_type error_vertex();
      vertex_type v;
      v = '0;
      v.coord_error = 1'b1;
      return v;
   endfunction

   // register write, only while idle
   task automatic write_reg(input uvs_pkg::reg_index_type idx, input logic [63:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         uvs_pkg::REG_RADIUS: radius_reg = value[15:0];
         uvs_pkg::REG_SLICES: slices_reg = value[7:0];
         uvs_pkg::REG_STACKS: stacks_reg = value[7:0];
         uvs_pkg::REG_COLOR:  color_reg  = value;
         default: ;
      endcase
      @(posedge clock);
   endtask

   // send one grid point; known result overrides the predictor
   task automatic send_point(input logic [7:0] ring, input logic [7:0] segment,
                             input bit has_known, input vertex_type known);
      vertex_type v;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      if (has_known) v = known;
      else compute_vertex(ring, segment, v);
      req_tvalid <= 1'b1;
      req_tdata  <= {segment, ring};
      do @(posedge clock); while (!req_tready);
      pending_vertices.insert(pending_vertices.size(), v);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_vertices.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   // random point, mostly inside the grid
   task automatic send_random();
      logic [7:0] ring, segment;
      int slices, stacks;
      slices = slices_reg < uvs_pkg::MIN_SLICES ? uvs_pkg::MIN_SLICES : slices_reg;
      stacks = stacks_reg < uvs_pkg::MIN_STACKS ? uvs_pkg::MIN_STACKS : stacks_reg;
      if ($urandom_range(9) == 0) begin
         ring = 8'($urandom);
         segment = 8'($urandom);
      end else begin
         ring = 8'($urandom_range(stacks));
         segment = 8'($urandom_range(slices));
      end
      send_point(ring, segment, 1'b0, '0);
   endtask

   // receiver stall
   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= !hold_rsp && ($urandom_range(99) >= recv_stall_pct);
   end

   // response checker
   always @(posedge clock) begin
      vertex_type want, got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.vertex_index = rsp_tdata[15:0];
         got.pos_x        = rsp_tdata[32:16];
         got.pos_y        = rsp_tdata[49:33];
         got.pos_z        = rsp_tdata[66:50];
         got.vertex_color = rsp_tdata[130:67];
         got.corner_a     = rsp_tdata[146:131];
         got.corner_b     = rsp_tdata[162:147];
         got.corner_c     = rsp_tdata[178:163];
         got.corner_d     = rsp_tdata[194:179];
         got.quad_valid   = rsp_tuser[0];
         got.coord_error  = rsp_tuser[1];
         if (pending_vertices.size() == 0) begin
            $display("%0t: unexpected vertex beat %h", $time, got);
            error_count++;
         end else begin
            want = pending_vertices.pop_front();
            if (got !== want) begin
               $display("%0t: vertex mismatch expected %h actual %h", $time, want, got);
               error_count++;
            end
         end
      end
   end

   // watchdog on cycles with no accepted beat
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready) || hold_rsp || rsp_free)
         idle_cycles <= 0;
      else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // long receiver hold-off, counted here
   initial begin
      hold_rsp = 1'b0;
      wait (!reset);
      repeat (3000) @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (400) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   initial begin
      row_type rows [N_ROWS];
      row_type rw;
      vertex_type north;
      error_count = 0;
      idle_cycles = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      rsp_free = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_valid = 1'b0;
      csr_index = uvs_pkg::REG_RADIUS;
      csr_data = '0;
      radius_reg = 16'd256;
      slices_reg = 8'd16;
      stacks_reg = 8'd8;
      color_reg = '1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: north pole after reset has position (0, 1.0, 0)
      north = '0;
      north.pos_y = 17'd256;
      north.vertex_color = '1;
      north.quad_valid = 1'b1;
      north.corner_b = 16'd1;
      north.corner_c = 16'd17;
      north.corner_d = 16'd18;
      rows[0]  = '{8'd0, 8'd0, 1'b1, north};
      rows[1]  = '{8'd8, 8'd16, 1'b0, '0};   // south pole, last segment
      rows[2]  = '{8'd0, 8'd16, 1'b0, '0};   // seam, no quad
      rows[3]  = '{8'd8, 8'd0, 1'b0, '0};    // last ring, no quad
      rows[4]  = '{8'd4, 8'd4, 1'b0, '0};
      rows[5]  = '{8'd7, 8'd15, 1'b0, '0};
      rows[6]  = '{8'd9, 8'd0, 1'b1, error_vertex()};    // ring off grid
      rows[7]  = '{8'd0, 8'd17, 1'b1, error_vertex()};   // segment off grid
      rows[8]  = '{8'd255, 8'd255, 1'b1, error_vertex()};
      rows[9]  = '{8'd170, 8'd85, 1'b1, error_vertex()};
      rows[10] = '{8'd85, 8'd170, 1'b1, error_vertex()};
      foreach (rows[i]) begin
         rw = rows[i];
         send_point(rw.ring, rw.segment, rw.has_known, rw.known);
      end
      drain();

      // counts below minimum, largest radius, alternating colour
      write_reg(uvs_pkg::REG_SLICES, 64'd0);
      write_reg(uvs_pkg::REG_STACKS, 64'd1);
      write_reg(uvs_pkg::REG_RADIUS, 64'hFFFF);
      write_reg(uvs_pkg::REG_COLOR, 64'hA5A5_5A5A_0F0F_F0F0);
      for (int r = 0; r <= 3; r++)
         for (int s = 0; s <= 4; s++)
            send_point(8'(r), 8'(s), 1'b0, '0);
      drain();

      // phase 0 full-size grid, phase 1 minimum grid, later phases random size, radius and colour; idle patterns
      for (int phase = 0; phase < 6; phase++) begin
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
            default: begin send_idle_pct = 31; recv_stall_pct = 31; end
         endcase
         case (phase)
            0: begin
               write_reg(uvs_pkg::REG_SLICES, 64'd255);
               write_reg(uvs_pkg::REG_STACKS, 64'd255);
               write_reg(uvs_pkg::REG_RADIUS, 64'd0);
               write_reg(uvs_pkg::REG_COLOR, 64'd0);
            end
            1: begin
               write_reg(uvs_pkg::REG_SLICES, 64'd3);
               write_reg(uvs_pkg::REG_STACKS, 64'd2);
               write_reg(uvs_pkg::REG_RADIUS, 64'h5555);
            end
            default: begin
               write_reg(uvs_pkg::REG_SLICES, 64'($urandom));
               write_reg(uvs_pkg::REG_STACKS, 64'($urandom));
               write_reg(uvs_pkg::REG_RADIUS, 64'($urandom));
               write_reg(uvs_pkg::REG_COLOR, {$urandom, $urandom});
            end
         endcase
         for (int n = 0; n < N_RANDOM / 6; n++) send_random();
         drain();
      end

      rsp_free = 1'b1;
      if (error_count == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule
